// ----- rtl/stereo_bass_treble_tone_control_assert.svh -----
// Assertion macros shared by the tone control RTL.
// Both expect signals named clk and arst_n in the calling module.
`ifndef STEREO_BASS_TREBLE_TONE_CONTROL_ASSERT_SVH
`define STEREO_BASS_TREBLE_TONE_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tone control assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tone control assertion failed");

`endif

// ----- rtl/stc_pkg.sv -----
`timescale 1ns / 1ps
package stc_pkg;

	// Default widths of samples and coefficient registers.
	localparam int SAMPLE_BITS_D = 24;
	localparam int COEF_BITS_D   = 32;

	// Configuration register map.
	localparam int NUM_REGS     = 8;
	localparam int CFG_IDX_BITS = 4;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TREBLE_NUM = 4'd0,
		REG_TREBLE_FB1 = 4'd1,
		REG_TREBLE_FB2 = 4'd2,
		REG_BASS_NUM   = 4'd3,
		REG_BASS_FB1   = 4'd4,
		REG_BASS_FB2   = 4'd5,
		REG_TREBLE_LVL = 4'd6,
		REG_DRIVE_LVL  = 4'd7
	} reg_idx_t;

	localparam logic signed [63:0] REG_RESET [NUM_REGS] = '{
		64'sd14777000, -64'sd250386000, 64'sd41049000, 64'sd27457500,
		-64'sd49118000, -64'sd109486000, 64'sd268435456, 64'sd268435456
	};

	// Filter memory: 2 sets x 2 channels x 2 filters x 2 words.
	localparam int FM_WIDTH = 40;
	localparam int FM_DEPTH = 16;

	// CORDIC constants, angles in Q.30.
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [35:0] PI_Q30          = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30      = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30     = 36'sd1686629713;
	localparam logic signed [35:0] CORDIC_GAIN_INV = 36'sd652032874;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD,
		ST_THETA,
		ST_WRAP,
		ST_SIN,
		ST_SOUT,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_B3,
		ST_B4,
		ST_B5,
		ST_V0,
		ST_V1,
		ST_V2,
		ST_V3,
		ST_SQRT,
		ST_AINIT,
		ST_ASIN,
		ST_ZOUT,
		ST_DONE
	} state_t;

	// Arctangent of 2^-i in Q.30; small angles equal the shift itself.
	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		logic signed [35:0] r;
		case (i)
			5'd0:    r = 36'sd843314857;
			5'd1:    r = 36'sd497837829;
			5'd2:    r = 36'sd263043837;
			5'd3:    r = 36'sd133525159;
			5'd4:    r = 36'sd67021687;
			5'd5:    r = 36'sd33543516;
			5'd6:    r = 36'sd16775851;
			5'd7:    r = 36'sd8388437;
			5'd8:    r = 36'sd4194283;
			5'd9:    r = 36'sd2097149;
			5'd10:   r = 36'sd1048576;
			default: r = 36'sd1 <<< (30 - int'(i));
		endcase
		return r;
	endfunction

	// Right shift that adds half an LSB and then floors.
	function automatic logic signed [65:0] rnd_sh(input logic signed [65:0] v, input int sh);
		return (v + ((66'sd1 <<< sh) >>> 1)) >>> sh;
	endfunction

	// Saturate to a signed range of w bits.
	function automatic logic signed [65:0] sat_w(input logic signed [65:0] v, input int w);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = (66'sd1 <<< (w - 1)) - 66'sd1;
		lo = -hi - 66'sd1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

endpackage

// ----- rtl/stc_in_if.sv -----
`timescale 1ns / 1ps
interface stc_in_if import stc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_D
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ----- rtl/stc_out_if.sv -----
`timescale 1ns / 1ps
interface stc_out_if import stc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_D
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ----- rtl/stc_ram.sv -----
`timescale 1ns / 1ps
module stc_ram import stc_pkg::*; #(
	parameter int WIDTH = FM_WIDTH,
	parameter int DEPTH = FM_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/stereo_bass_treble_tone_control.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// din      in         din.valid/ready      left_in, right_in
// dout     out        dout.valid/ready     left_out, right_out
// cfg      in         cfg_we (no wait)     cfg_index, cfg_wdata
//
// One stereo pair passes through both channels in turn, from its transfer to the output
// register; each channel's drive angle is wrapped one turn at a time in the wrap state.
// Each channel runs a 30-step sine CORDIC, two biquads on the shared multiplier,
// a 31-step square root and a 30-step arcsine CORDIC. din.ready is high only while
// idle. A finished pair waits until the output register is free; the next pair is
// taken once it has moved there.
// Reset clears the filter memory through per-word valid bits, no sweep.
`include "stereo_bass_treble_tone_control_assert.svh"
module stereo_bass_treble_tone_control import stc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_D,
	parameter int COEF_BITS   = COEF_BITS_D
) (
	input  logic                    clk,
	input  logic                    arst_n,
	stc_in_if.sink                  din,
	stc_out_if.source               dout,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]    cfg_wdata
);
	localparam int XSH = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
	localparam int XUP = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
	localparam int CSH = (COEF_BITS > 32) ? COEF_BITS - 32 : 0;
	localparam int CUP = (COEF_BITS < 32) ? 32 - COEF_BITS : 0;
	localparam int OSH = 32 - SAMPLE_BITS;
	localparam int FM_AW = $clog2(FM_DEPTH);
	localparam int REG_AW = $clog2(NUM_REGS);

	state_t state_q, state_d;

	logic [COEF_BITS-1:0]          cfg_q [NUM_REGS];
	logic signed [SAMPLE_BITS-1:0] in_l_q, in_r_q, res_l_q, res_r_q, out_l_q, out_r_q;
	logic                          out_vld_q, phase_q, ch_q, f_q;
	logic [4:0]                    it_q;
	logic signed [63:0]            prod_q;
	logic signed [35:0]            cx_q, cy_q, cz_q;
	logic signed [23:0]            s_q;
	logic signed [55:0]            sa_q;
	logic signed [39:0]            y28_q, m1_q;
	logic signed [31:0]            yq_q, tr_q, yb_q, v_q;
	logic [60:0]                   sq_n_q, sq_r_q;
	logic [FM_DEPTH-1:0]           mem_vld_q;
	logic                          rvld_q;

	// Sequencer outputs.
	reg_idx_t                 coef_sel;
	logic signed [31:0]       mul_a, mul_b;
	logic                     ram_we, out_load;
	logic [FM_AW-1:0]         ram_waddr, ram_raddr;
	logic [FM_WIDTH-1:0]      ram_wdata, ram_rdata;

	// Datapath values.
	logic signed [65:0] coef_w, x_w, theta_w, y28_w, yq_w, w0_w, w1_w, tr_w, v_w, z_w;
	logic signed [31:0] coef;
	logic signed [63:0] prod_w;
	logic signed [35:0] cx_sh, cy_sh, at;
	logic signed [39:0] m0;
	logic [60:0]        sq_bit;
	logic [61:0]        sq_t;
	logic               sq_ge;

	// Configuration registers; writes beyond the map are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RESET[i][COEF_BITS-1:0];
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_BITS'(NUM_REGS))) begin
			cfg_q[cfg_index[REG_AW-1:0]] <= cfg_wdata;
		end
	end

	// Coefficient select and normalization to Q4.28.
	always_comb begin
		coef_w = sat_w(rnd_sh(66'($signed(cfg_q[coef_sel[REG_AW-1:0]])), CSH) <<< CUP, 32);
		coef   = $signed(coef_w[31:0]);
	end

	// Shared multiplier with its product register.
	assign prod_w = mul_a * mul_b;
	always_ff @(posedge clk) begin
		prod_q <= prod_w;
	end

	// Arithmetic for the individual steps.
	always_comb begin
		x_w     = sat_w(rnd_sh(66'(ch_q ? in_r_q : in_l_q), XSH) <<< XUP, 24);
		theta_w = rnd_sh(66'(prod_q), 21);
		cx_sh   = cx_q >>> it_q;
		cy_sh   = cy_q >>> it_q;
		at      = atan_q30(it_q);
		m0      = rvld_q ? $signed(ram_rdata) : 40'sd0;
		y28_w   = sat_w(rnd_sh(66'(prod_q), 23) + 66'(m0), 40);
		yq_w    = sat_w(rnd_sh(66'(y28_q), 5), 32);
		w0_w    = sat_w(rnd_sh((66'(sa_q) <<< 1) - 66'(prod_q), 23) + 66'(m1_q), 40);
		w1_w    = sat_w(rnd_sh(66'(sa_q) - 66'(prod_q), 23), 40);
		tr_w    = sat_w(66'(s_q) - 66'(yq_q), 32);
		v_w     = rnd_sh(66'(prod_q) + (66'(yb_q) <<< 28), 21);
		if (v_w > 66'sd1073741824) begin
			v_w = 66'sd1073741824;
		end else if (v_w < -66'sd1073741824) begin
			v_w = -66'sd1073741824;
		end
		sq_bit  = 61'd1 << (60 - 2 * int'(it_q));
		sq_t    = {1'b0, sq_r_q} + {1'b0, sq_bit};
		sq_ge   = {1'b0, sq_n_q} >= sq_t;
		z_w     = sat_w(rnd_sh(66'(cz_q), OSH), SAMPLE_BITS);
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d   = state_q;
		coef_sel  = REG_DRIVE_LVL;
		mul_a     = '0;
		mul_b     = '0;
		ram_we    = 1'b0;
		ram_waddr = {phase_q, ch_q, f_q, 1'b0};
		ram_raddr = {phase_q, ch_q, f_q, 1'b0};
		ram_wdata = w0_w[FM_WIDTH-1:0];
		out_load  = 1'b0;
		din.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				mul_a   = x_w[31:0];
				mul_b   = coef;
				state_d = ST_THETA;
			end
			ST_THETA: state_d = ST_WRAP;
			ST_WRAP: begin
				if (!(cz_q > PI_Q30) && !(cz_q < -PI_Q30)) begin
					state_d = ST_SIN;
				end
			end
			ST_SIN: begin
				if (it_q == 5'(CORDIC_STEPS - 1)) begin
					state_d = ST_SOUT;
				end
			end
			ST_SOUT: state_d = ST_B0;
			ST_B0: begin
				coef_sel = f_q ? REG_BASS_NUM : REG_TREBLE_NUM;
				mul_a    = 32'(s_q);
				mul_b    = coef;
				state_d  = ST_B1;
			end
			ST_B1: begin
				ram_raddr = {phase_q, ch_q, f_q, 1'b1};
				state_d   = ST_B2;
			end
			ST_B2: state_d = ST_B3;
			ST_B3: begin
				coef_sel = f_q ? REG_BASS_FB1 : REG_TREBLE_FB1;
				mul_a    = yq_q;
				mul_b    = coef;
				state_d  = ST_B4;
			end
			ST_B4: begin
				coef_sel = f_q ? REG_BASS_FB2 : REG_TREBLE_FB2;
				mul_a    = yq_q;
				mul_b    = coef;
				ram_we   = 1'b1;
				state_d  = ST_B5;
			end
			ST_B5: begin
				ram_we    = 1'b1;
				ram_waddr = {phase_q, ch_q, f_q, 1'b1};
				ram_wdata = w1_w[FM_WIDTH-1:0];
				state_d   = f_q ? ST_V0 : ST_B0;
			end
			ST_V0: begin
				coef_sel = REG_TREBLE_LVL;
				mul_a    = tr_q;
				mul_b    = coef;
				state_d  = ST_V1;
			end
			ST_V1: state_d = ST_V2;
			ST_V2: begin
				mul_a   = v_q;
				mul_b   = v_q;
				state_d = ST_V3;
			end
			ST_V3: state_d = ST_SQRT;
			ST_SQRT: begin
				if (it_q == 5'd30) begin
					state_d = ST_AINIT;
				end
			end
			ST_AINIT: state_d = ST_ASIN;
			ST_ASIN: begin
				if (it_q == 5'(CORDIC_STEPS - 1)) begin
					state_d = ST_ZOUT;
				end
			end
			ST_ZOUT: state_d = ch_q ? ST_DONE : ST_LOAD;
			ST_DONE: begin
				if (!out_vld_q || dout.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				in_l_q <= din.left_in;
				in_r_q <= din.right_in;
			end
			ST_THETA: cz_q <= theta_w[35:0];
			ST_WRAP: begin
				cx_q <= CORDIC_GAIN_INV;
				cy_q <= '0;
				if (cz_q > PI_Q30) begin
					cz_q <= cz_q - TWO_PI_Q30;
				end else if (cz_q < -PI_Q30) begin
					cz_q <= cz_q + TWO_PI_Q30;
				end else if (cz_q > HALF_PI_Q30) begin
					cz_q <= PI_Q30 - cz_q;
				end else if (cz_q < -HALF_PI_Q30) begin
					cz_q <= -PI_Q30 - cz_q;
				end
			end
			ST_SIN: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					cz_q <= cz_q + at;
				end
			end
			ST_SOUT: s_q <= 24'(sat_w(rnd_sh(66'(cy_q), 7), 24));
			ST_B1: begin
				sa_q  <= prod_q[55:0];
				y28_q <= y28_w[39:0];
			end
			ST_B2: begin
				m1_q <= m0;
				yq_q <= yq_w[31:0];
			end
			ST_B5: begin
				if (f_q) begin
					yb_q <= yq_q;
				end else begin
					tr_q <= tr_w[31:0];
				end
			end
			ST_V1: v_q <= v_w[31:0];
			ST_V3: begin
				sq_n_q <= (61'd1 << 60) - prod_q[60:0];
				sq_r_q <= '0;
			end
			ST_SQRT: begin
				if (sq_ge) begin
					sq_n_q <= sq_n_q - sq_t[60:0];
					sq_r_q <= (sq_r_q >> 1) + sq_bit;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
			end
			ST_AINIT: begin
				cx_q <= $signed({5'd0, sq_r_q[30:0]});
				cy_q <= 36'(v_q);
				cz_q <= '0;
			end
			ST_ASIN: begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					cz_q <= cz_q + at;
				end else begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					cz_q <= cz_q - at;
				end
			end
			ST_ZOUT: begin
				if (ch_q) begin
					res_r_q <= z_w[SAMPLE_BITS-1:0];
				end else begin
					res_l_q <= z_w[SAMPLE_BITS-1:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_l_q <= res_l_q;
			out_r_q <= res_r_q;
		end
	end

	// Control counters: channel, filter and step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= 1'b0;
			f_q  <= 1'b0;
			it_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: ch_q <= 1'b0;
				ST_WRAP, ST_V3, ST_AINIT: it_q <= '0;
				ST_SIN, ST_SQRT, ST_ASIN: it_q <= it_q + 5'd1;
				ST_SOUT: f_q <= 1'b0;
				ST_B5: f_q <= 1'b1;
				ST_ZOUT: ch_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Output valid, filter set toggle and per-word valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			phase_q   <= 1'b0;
			mem_vld_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
				phase_q   <= ~phase_q;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ram_we) begin
				mem_vld_q[ram_waddr] <= 1'b1;
			end
			rvld_q <= mem_vld_q[ram_raddr];
		end
	end

	stc_ram #(
		.WIDTH(FM_WIDTH),
		.DEPTH(FM_DEPTH)
	) u_fmem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign dout.valid     = out_vld_q;
	assign dout.left_out  = out_l_q;
	assign dout.right_out = out_r_q;

	// Checks on the sequencer and the square root.
	`STC_ASSERT_SAME(a_ram_we_state, ram_we, (state_q == ST_B4) || (state_q == ST_B5))
	`STC_ASSERT_NEXT(a_load_valid, out_load, dout.valid)
	`STC_ASSERT_NEXT(a_phase_toggle, out_load, phase_q != $past(phase_q))
	`STC_ASSERT_SAME(a_sqrt_rem, state_q == ST_AINIT, sq_n_q <= (sq_r_q << 1))
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import stc_pkg::*;

	localparam int SB = SAMPLE_BITS_D;
	localparam int CB = COEF_BITS_D;

	typedef struct {
		logic [SB-1:0] left;
		logic [SB-1:0] right;
	} pair_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CB-1:0] cfg_wdata;

	stc_in_if  #(.SAMPLE_BITS(SB)) din_if ();
	stc_out_if #(.SAMPLE_BITS(SB)) dout_if ();

	stereo_bass_treble_tone_control #(.SAMPLE_BITS(SB), .COEF_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n), .din(din_if), .dout(dout_if),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Predictor state: coefficient registers, filter memory and the set toggle.
	longint coefs [NUM_REGS];
	longint fmem [2][2][2][2];
	bit     set_sel;
	pair_t  expected_pairs [$];

	int err_count;
	int pairs_sent;
	int pairs_checked;
	int hold_cycles;

	localparam longint PI30     = 64'sd3373259426;
	localparam longint TWO_PI30 = 64'sd6746518852;
	localparam longint HPI30    = 64'sd1686629713;
	localparam longint KINV     = 64'sd652032874;
	localparam longint ONE30    = 64'sd1073741824;

	localparam longint ATAN_TAB [11] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint round_shift(longint v, int sh);
		if (sh == 0)
			return v;
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip(longint v, int w);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic longint angle_step(int i);
		return (i < 11) ? ATAN_TAB[i] : (64'sd1 <<< (30 - i));
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Rotation CORDIC sine of a Q.30 angle, Q1.23 result.
	function automatic longint sine_of(longint th);
		longint x;
		longint y;
		longint nx;
		x = KINV;
		y = 0;
		while (th > PI30) th = th - TWO_PI30;
		while (th < -PI30) th = th + TWO_PI30;
		if (th > HPI30) th = PI30 - th;
		if (th < -HPI30) th = -PI30 - th;
		for (int i = 0; i < 30; i++) begin
			if (th >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); th = th - angle_step(i);
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); th = th + angle_step(i);
			end
			x = nx;
		end
		return clip(round_shift(y, 7), 24);
	endfunction

	// Vectoring CORDIC arcsine of a Q.30 value, Q.30 radians.
	function automatic longint arcsine_of(longint v);
		longint x;
		longint y;
		longint z;
		longint nx;
		x = longint'(int_sqrt((64'd1 << 60) - longint'(v * v)));
		y = v;
		z = 0;
		for (int i = 0; i < 30; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z = z + angle_step(i);
			end else begin
				nx = x - (y >>> i); y = y + (x >>> i); z = z - angle_step(i);
			end
			x = nx;
		end
		return z;
	endfunction

	// Lowpass biquad with a1 = 2*a0 and a2 = a0, memory in Q.28.
	function automatic longint lowpass(longint s, longint a0, longint b1, longint b2,
			inout longint m0, inout longint m1);
		longint y28;
		longint yq;
		y28 = clip(round_shift(s * a0, 23) + m0, 40);
		yq  = clip(round_shift(y28, 5), 32);
		m0  = clip(round_shift(s * (2 * a0) - yq * b1, 23) + m1, 40);
		m1  = clip(round_shift(s * a0 - yq * b2, 23), 40);
		return yq;
	endfunction

	function automatic logic [SB-1:0] tone_channel(logic [SB-1:0] raw, int ch);
		longint x;
		longint s;
		longint yt;
		longint yb;
		longint tr;
		longint v;
		longint z;
		x  = longint'($signed(raw));
		s  = sine_of(round_shift(x * coefs[REG_DRIVE_LVL], 21));
		yt = lowpass(s, coefs[REG_TREBLE_NUM], coefs[REG_TREBLE_FB1], coefs[REG_TREBLE_FB2],
			fmem[set_sel][ch][0][0], fmem[set_sel][ch][0][1]);
		tr = clip(s - yt, 32);
		yb = lowpass(s, coefs[REG_BASS_NUM], coefs[REG_BASS_FB1], coefs[REG_BASS_FB2],
			fmem[set_sel][ch][1][0], fmem[set_sel][ch][1][1]);
		v  = round_shift(tr * coefs[REG_TREBLE_LVL] + yb * (64'sd1 <<< 28), 21);
		if (v > ONE30) v = ONE30;
		if (v < -ONE30) v = -ONE30;
		z = clip(round_shift(arcsine_of(v), 8), SB);
		return z[SB-1:0];
	endfunction

	task automatic predict_pair(logic [SB-1:0] l, logic [SB-1:0] r);
		pair_t p;
		p.left  = tone_channel(l, 0);
		p.right = tone_channel(r, 1);
		set_sel = ~set_sel;
		expected_pairs.push_back(p);
	endtask

	task automatic report(string what, logic [SB-1:0] got, logic [SB-1:0] want);
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
			pairs_checked);
		err_count++;
	endtask

	// Register write; only called while nothing is in flight.
	task automatic write_reg(int idx, logic [CB-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx[CFG_IDX_BITS-1:0];
		cfg_wdata <= val;
		@(posedge clk);
		if (idx < NUM_REGS)
			coefs[idx] = longint'($signed(val));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(logic [CB-1:0] v0, logic [CB-1:0] v1, logic [CB-1:0] v2,
			logic [CB-1:0] v3, logic [CB-1:0] v4, logic [CB-1:0] v5,
			logic [CB-1:0] v6, logic [CB-1:0] v7);
		write_reg(REG_TREBLE_NUM, v0);
		write_reg(REG_TREBLE_FB1, v1);
		write_reg(REG_TREBLE_FB2, v2);
		write_reg(REG_BASS_NUM, v3);
		write_reg(REG_BASS_FB1, v4);
		write_reg(REG_BASS_FB2, v5);
		write_reg(REG_TREBLE_LVL, v6);
		write_reg(REG_DRIVE_LVL, v7);
	endtask

	task automatic load_reset_regs();
		load_regs(REG_RESET[0][CB-1:0], REG_RESET[1][CB-1:0], REG_RESET[2][CB-1:0],
			REG_RESET[3][CB-1:0], REG_RESET[4][CB-1:0], REG_RESET[5][CB-1:0],
			REG_RESET[6][CB-1:0], REG_RESET[7][CB-1:0]);
	endtask

	// Offers one pair after a random gap, or none with no_gap; valid stays high on return.
	task automatic send_pair(logic [SB-1:0] l, logic [SB-1:0] r, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid    <= 1'b1;
		din_if.left_in  <= l;
		din_if.right_in <= r;
		do @(posedge clk); while (!din_if.ready);
		predict_pair(l, r);
		pairs_sent++;
	endtask

	task automatic wait_drained();
		din_if.valid <= 1'b0;
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [SB-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return SB'($urandom_range(0, 255) - 128);
			1: return SB'((1 << (SB - 1)) - $urandom_range(1, 16));
			2: return SB'((1 << (SB - 1)) + $urandom_range(0, 15));
			default: return SB'($urandom());
		endcase
	endfunction

	// Result side: random stalls, none in every third run of 64 results, plus long hold-offs on request.
	initial begin
		int stall;
		pair_t want;
		dout_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 7) + hold_cycles;
			hold_cycles = 0;
			if ((pairs_checked / 64) % 3 == 2)
				stall = 0;
			if (stall > 0) begin
				dout_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_if.ready <= 1'b1;
			do @(posedge clk); while (!dout_if.valid);
			if (expected_pairs.size() == 0) begin
				$display("unexpected result %h %h", dout_if.left_out, dout_if.right_out);
				err_count++;
			end else begin
				want = expected_pairs.pop_front();
				if (dout_if.left_out !== want.left)
					report("left_out", dout_if.left_out, want.left);
				if (dout_if.right_out !== want.right)
					report("right_out", dout_if.right_out, want.right);
			end
			pairs_checked++;
		end
	end

	task automatic test_directed();
		send_pair('0, '0);
		send_pair(24'h7fffff, 24'h800000);
		send_pair(24'h800000, 24'h7fffff);
		send_pair(24'hffffff, 24'h000001);
		send_pair(24'h400000, 24'hc00000);
		wait_drained();
		// Drive near a quarter turn so the sine reaches plus one.
		write_reg(REG_DRIVE_LVL, 32'd421657428);
		send_pair(24'h7fffff, 24'h800000);
		send_pair(24'h7fffff, 24'h7fffff);
		wait_drained();
		// Large treble gain pushes the path sum past the clamp.
		write_reg(REG_TREBLE_LVL, 32'h7fffffff);
		send_pair(24'h7fffff, 24'h800000);
		send_pair(24'h800000, 24'h7fffff);
		send_pair(24'h123456, 24'hedcba9);
		wait_drained();
		write_reg(REG_TREBLE_LVL, 32'h80000000);
		send_pair(24'h7fffff, 24'h800000);
		send_pair(24'h000000, 24'h7fffff);
		wait_drained();
		// Writes beyond the register map are dropped.
		write_reg(NUM_REGS, 32'h0);
		write_reg(NUM_REGS + 7, 32'hffffffff);
		send_pair(24'h7fffff, 24'h800000);
		wait_drained();
		// Unstable extreme coefficients drive the filter memory into saturation.
		load_regs(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		for (int i = 0; i < 6; i++)
			send_pair(24'h7fffff, 24'h800000);
		wait_drained();
	endtask

	task automatic test_settings();
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: load_regs(0, 0, 0, 0, 0, 0, 0, 0);
				1: load_regs(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
					32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
				default: load_regs($urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom());
			endcase
			for (int i = 0; i < 30; i++)
				send_pair(rand_sample(), rand_sample());
			wait_drained();
		end
		load_reset_regs();
	endtask

	task automatic test_random();
		for (int i = 0; i < 800; i++) begin
			if (i % 200 == 100) begin
				wait_drained();
				write_reg(REG_DRIVE_LVL, $urandom_range(0, 32'h30000000));
				write_reg(REG_TREBLE_LVL, $urandom_range(0, 32'h40000000));
			end
			send_pair(rand_sample(), rand_sample(), (i / 50) % 4 == 3);
		end
		wait_drained();
		load_reset_regs();
	endtask

	task automatic test_backpressure();
		hold_cycles = 1500;
		for (int i = 0; i < 8; i++)
			send_pair(rand_sample(), rand_sample(), 1);
		wait_drained();
		for (int i = 0; i < 8; i++) begin
			send_pair(rand_sample(), rand_sample());
			wait_drained();
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++)
			coefs[i] = longint'($signed(REG_RESET[i][CB-1:0]));
		fmem = '{default: 0};
		set_sel = 0;
		err_count = 0;
		pairs_sent = 0;
		pairs_checked = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		din_if.valid = 1'b0;
		din_if.left_in = '0;
		din_if.right_in = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_settings();
		test_random();
		test_backpressure();

		repeat (600) @(posedge clk);
		$display("Sent %0d stereo pairs and checked %0d results across", pairs_sent,
			pairs_checked);
		$display("extreme, random and default coefficient settings with back-pressure.");
		if (err_count == 0 && expected_pairs.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("timeout after %0d results", pairs_checked);
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/stc_pkg.sv
rtl/stc_in_if.sv
rtl/stc_out_if.sv
rtl/stc_ram.sv
rtl/stereo_bass_treble_tone_control.sv
tb/tb_top.sv
